/* hdl/ps2_mouse_cursor_tracker_assert.svh */
// Assertion macros for the cursor tracker. Clock i_clk, reset i_rst_n.
`ifndef PS2_MOUSE_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_CURSOR_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define PMCT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pmct assertion failed");
`define PMCT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pmct assertion failed");
`else
`define PMCT_ASSERT_IMP(lbl, ante, cons)
`define PMCT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hdl/pmct_pkg.sv */
package pmct_pkg;

    localparam int POS_W    = 10;   // cursor coordinate width
    localparam int CALC_W   = 13;   // signed width for position plus delta
    localparam int CFG_W    = 16;   // widest configuration register
    localparam int CFG_IDX_W = 3;
    localparam int STAMP_W_DEF = 32;
    localparam int STAMP_IN_W = 32;
    localparam int WINDOW_W = 16;
    localparam int SIZE_W   = 10;
    localparam int SPR_W    = 6;
    localparam int TMAX_W   = 7;

    localparam logic [TMAX_W-1:0] TEXT_X_MAX = 7'd79;
    localparam logic [TMAX_W-1:0] TEXT_Y_MAX = 7'd24;

    localparam logic [POS_W-1:0] POS_X_RST = 10'd40;
    localparam logic [POS_W-1:0] POS_Y_RST = 10'd12;

    localparam logic [SIZE_W-1:0]   SCREEN_W_RST = 10'd320;
    localparam logic [SIZE_W-1:0]   SCREEN_H_RST = 10'd200;
    localparam logic [SPR_W-1:0]    SPRITE_W_RST = 6'd8;
    localparam logic [SPR_W-1:0]    SPRITE_H_RST = 6'd8;
    localparam logic [WINDOW_W-1:0] WINDOW_RST   = 16'd256;

    // icon hot areas
    localparam logic [POS_W-1:0] ICON_X_LO  = 10'd10;
    localparam logic [POS_W-1:0] ICON_X_HI  = 10'd30;
    localparam logic [POS_W-1:0] ICON1_Y_LO = 10'd10;
    localparam logic [POS_W-1:0] ICON1_Y_HI = 10'd30;
    localparam logic [POS_W-1:0] ICON2_Y_LO = 10'd40;
    localparam logic [POS_W-1:0] ICON2_Y_HI = 10'd60;

    // status byte bits
    localparam int ST_LEFT  = 0;
    localparam int ST_XSIGN = 4;
    localparam int ST_YSIGN = 5;
    localparam int ST_XOVF  = 6;
    localparam int ST_YOVF  = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAPHICS,
        CFG_SCREEN_W,
        CFG_SCREEN_H,
        CFG_SPRITE_W,
        CFG_SPRITE_H,
        CFG_WINDOW
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_ICON_ONE,
        ACT_ICON_TWO,
        ACT_RECOLOR
    } t_action;

    typedef struct packed {
        logic              gfx;
        logic [SIZE_W-1:0] size;
        logic [SPR_W-1:0]  spr;
        logic [TMAX_W-1:0] text_max;
    } t_axis_cfg;

endpackage

/* hdl/pmct_in_if.sv */
interface pmct_in_if
    import pmct_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [7:0]            rx_byte;
    logic [STAMP_IN_W-1:0] time_stamp;

    modport source (output valid, output rx_byte, output time_stamp, input ready);
    modport sink   (input valid, input rx_byte, input time_stamp, output ready);
endinterface

/* hdl/pmct_out_if.sv */
interface pmct_out_if
    import pmct_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] cursor_x;
    logic [POS_W-1:0] cursor_y;
    logic             left_pressed;
    logic             packet_dropped;
    logic [1:0]       action;
    logic [7:0]       color_attr;

    modport source (output valid, output cursor_x, output cursor_y, output left_pressed,
                    output packet_dropped, output action, output color_attr, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, input left_pressed,
                    input packet_dropped, input action, input color_attr, output ready);
endinterface

/* hdl/ps2_mouse_cursor_tracker.sv */
// PS/2 mouse cursor tracker. Takes one mouse byte per item with its tick stamp,
// groups bytes in threes (status, X, Y) and emits one result item for each third
// byte; the first two bytes of a packet give no result. A packet with an overflow
// bit is reported as dropped and leaves the cursor alone. An item is accepted every
// cycle as long as the result register is free or being emptied; a byte is captured
// in the input register when it is accepted, and its result is loaded into the result
// register once that register is free or being emptied, with the decode, the 9-bit
// delta add and the clamp between the two registers. Configuration (index 0 graphics
// mode, 1/2 screen size, 3/4 sprite size, 5 double-click window) is to be written by
// the user only while no packet is in flight; the block does not enforce this.
module ps2_mouse_cursor_tracker
    import pmct_pkg::*;
#(
    parameter int STAMP_WIDTH = STAMP_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    pmct_in_if.sink              i_rx,
    pmct_out_if.source           o_res
);

    `include "ps2_mouse_cursor_tracker_assert.svh"

    localparam int CMP_W = (STAMP_WIDTH > WINDOW_W) ? STAMP_WIDTH : WINDOW_W;

    typedef enum logic [1:0] {
        SLOT_STATUS,
        SLOT_X,
        SLOT_Y
    } t_slot;

    // configuration
    logic                r_gfx;
    logic [SIZE_W-1:0]   r_scr_w;
    logic [SIZE_W-1:0]   r_scr_h;
    logic [SPR_W-1:0]    r_spr_w;
    logic [SPR_W-1:0]    r_spr_h;
    logic [WINDOW_W-1:0] r_window;

    // input register
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic [STAMP_WIDTH-1:0] r_in_stamp;

    // tracker state
    t_slot                  r_slot;
    logic [7:0]             r_status;
    logic [7:0]             r_x_byte;
    logic [POS_W-1:0]       r_pos_x;
    logic [POS_W-1:0]       r_pos_y;
    logic [STAMP_WIDTH-1:0] r_last;
    logic                   r_press_seen;
    logic                   r_dflag;

    // result register
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_x;
    logic [POS_W-1:0] r_out_y;
    logic             r_out_left;
    logic             r_out_drop;
    t_action          r_out_act;
    logic [7:0]       r_out_color;

    // next values
    t_slot                  n_slot;
    logic [7:0]             n_status;
    logic [7:0]             n_x_byte;
    logic [POS_W-1:0]       n_pos_x;
    logic [POS_W-1:0]       n_pos_y;
    logic [STAMP_WIDTH-1:0] n_last;
    logic                   n_press_seen;
    logic                   n_dflag;
    logic                   n_has_res;
    logic                   n_left;
    logic                   n_drop;
    t_action                n_act;
    logic [7:0]             n_color;

    logic                     w_out_free;
    logic                     w_s1_go;
    logic signed [CALC_W-1:0] w_nx;
    logic signed [CALC_W-1:0] w_ny;
    logic [POS_W-1:0]         w_cx;
    logic [POS_W-1:0]         w_cy;
    t_axis_cfg                w_cfg_x;
    t_axis_cfg                w_cfg_y;
    logic [STAMP_WIDTH-1:0]   w_diff;
    logic                     w_hit;
    logic                     w_flag;
    logic [3:0]               w_c;

    assign n_has_res  = r_in_valid && (r_slot == SLOT_Y);
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_s1_go    = r_in_valid && (!n_has_res || w_out_free);
    assign i_rx.ready = !r_in_valid || w_s1_go;

    assign w_nx = $signed(CALC_W'(r_pos_x))
                + $signed({{(CALC_W-8){r_status[ST_XSIGN]}}, r_x_byte});
    assign w_ny = $signed(CALC_W'(r_pos_y))
                - $signed({{(CALC_W-8){r_status[ST_YSIGN]}}, r_in_byte});

    assign w_cfg_x = '{gfx: r_gfx, size: r_scr_w, spr: r_spr_w, text_max: TEXT_X_MAX};
    assign w_cfg_y = '{gfx: r_gfx, size: r_scr_h, spr: r_spr_h, text_max: TEXT_Y_MAX};

    pmct_clamp u_clamp_x (
        .i_pos (w_nx),
        .i_cfg (w_cfg_x),
        .o_pos (w_cx)
    );

    pmct_clamp u_clamp_y (
        .i_pos (w_ny),
        .i_cfg (w_cfg_y),
        .o_pos (w_cy)
    );

    // press interval, wraps at the stamp width
    assign w_diff = r_in_stamp - r_last;
    assign w_hit  = CMP_W'(w_diff) <= CMP_W'(r_window);
    assign w_c    = r_in_stamp[3:0];

    always_comb begin
        n_slot       = r_slot;
        n_status     = r_status;
        n_x_byte     = r_x_byte;
        n_pos_x      = r_pos_x;
        n_pos_y      = r_pos_y;
        n_last       = r_last;
        n_press_seen = r_press_seen;
        n_dflag      = r_dflag;
        n_left       = 1'b0;
        n_drop       = 1'b0;
        n_act        = ACT_NONE;
        n_color      = '0;
        w_flag       = r_dflag;
        unique case (r_slot)
            SLOT_X: begin
                n_x_byte = r_in_byte;
                n_slot   = SLOT_Y;
            end
            SLOT_Y: begin
                n_slot = SLOT_STATUS;
                if (r_status[ST_XOVF] || r_status[ST_YOVF]) begin
                    n_drop = 1'b1;
                end else begin
                    n_left = r_status[ST_LEFT];
                    if (r_status[ST_LEFT]) begin
                        n_press_seen = 1'b1;
                        n_last       = r_in_stamp;
                        if (r_press_seen) begin
                            w_flag = w_hit;
                        end
                    end
                    n_pos_x = w_cx;
                    n_pos_y = w_cy;
                    n_dflag = w_flag;
                    if (w_flag) begin
                        if (r_gfx) begin
                            if (w_cx >= ICON_X_LO && w_cx <= ICON_X_HI &&
                                w_cy >= ICON1_Y_LO && w_cy <= ICON1_Y_HI) begin
                                n_act   = ACT_ICON_ONE;
                                n_dflag = 1'b0;
                            end else if (w_cx >= ICON_X_LO && w_cx <= ICON_X_HI &&
                                         w_cy >= ICON2_Y_LO && w_cy <= ICON2_Y_HI) begin
                                n_act   = ACT_ICON_TWO;
                                n_dflag = 1'b0;
                            end
                        end else begin
                            n_act   = ACT_RECOLOR;
                            n_color = {~w_c, w_c};
                            n_dflag = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_status = r_in_byte;
                n_slot   = SLOT_X;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gfx    <= 1'b0;
            r_scr_w  <= SCREEN_W_RST;
            r_scr_h  <= SCREEN_H_RST;
            r_spr_w  <= SPRITE_W_RST;
            r_spr_h  <= SPRITE_H_RST;
            r_window <= WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRAPHICS: r_gfx    <= i_cfg_data[0];
                CFG_SCREEN_W: r_scr_w  <= i_cfg_data[SIZE_W-1:0];
                CFG_SCREEN_H: r_scr_h  <= i_cfg_data[SIZE_W-1:0];
                CFG_SPRITE_W: r_spr_w  <= i_cfg_data[SPR_W-1:0];
                CFG_SPRITE_H: r_spr_h  <= i_cfg_data[SPR_W-1:0];
                CFG_WINDOW:   r_window <= i_cfg_data[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte  <= i_rx.rx_byte;
            r_in_stamp <= STAMP_WIDTH'(i_rx.time_stamp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot       <= SLOT_STATUS;
            r_status     <= '0;
            r_x_byte     <= '0;
            r_pos_x      <= POS_X_RST;
            r_pos_y      <= POS_Y_RST;
            r_last       <= '0;
            r_press_seen <= 1'b0;
            r_dflag      <= 1'b0;
        end else if (w_s1_go) begin
            r_slot       <= n_slot;
            r_status     <= n_status;
            r_x_byte     <= n_x_byte;
            r_pos_x      <= n_pos_x;
            r_pos_y      <= n_pos_y;
            r_last       <= n_last;
            r_press_seen <= n_press_seen;
            r_dflag      <= n_dflag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && n_has_res) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_s1_go && n_has_res) begin
            r_out_x     <= n_pos_x;
            r_out_y     <= n_pos_y;
            r_out_left  <= n_left;
            r_out_drop  <= n_drop;
            r_out_act   <= n_act;
            r_out_color <= n_color;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.cursor_x       = r_out_x;
    assign o_res.cursor_y       = r_out_y;
    assign o_res.left_pressed   = r_out_left;
    assign o_res.packet_dropped = r_out_drop;
    assign o_res.action         = r_out_act;
    assign o_res.color_attr     = r_out_color;

    `PMCT_ASSERT_NXT(a_result_follows, w_s1_go && n_has_res, o_res.valid)
    `PMCT_ASSERT_IMP(a_drop_quiet, o_res.valid && o_res.packet_dropped,
        o_res.action == ACT_NONE && !o_res.left_pressed && o_res.color_attr == 8'd0)
    `PMCT_ASSERT_IMP(a_color_only_recolor, o_res.valid && o_res.action != ACT_RECOLOR,
        o_res.color_attr == 8'd0)
    `PMCT_ASSERT_IMP(a_icon_one_area, o_res.valid && o_res.action == ACT_ICON_ONE,
        o_res.cursor_x >= ICON_X_LO && o_res.cursor_x <= ICON_X_HI &&
        o_res.cursor_y >= ICON1_Y_LO && o_res.cursor_y <= ICON1_Y_HI)

endmodule

/* hdl/pmct_clamp.sv */
module pmct_clamp
    import pmct_pkg::*;
(
    input  logic signed [CALC_W-1:0] i_pos,
    input  t_axis_cfg                i_cfg,
    output logic [POS_W-1:0]         o_pos
);

    logic signed [CALC_W-1:0] w_half;
    logic signed [CALC_W-1:0] w_size;
    logic signed [CALC_W-1:0] w_tmax;
    logic signed [CALC_W-1:0] w_one;
    logic signed [CALC_W-1:0] w_lo;
    logic signed [CALC_W-1:0] w_hi;
    logic signed [CALC_W-1:0] w_res;

    assign w_half = $signed(CALC_W'(i_cfg.spr[SPR_W-1:1]));
    assign w_size = $signed(CALC_W'(i_cfg.size));
    assign w_tmax = $signed(CALC_W'(i_cfg.text_max));
    assign w_one  = $signed(CALC_W'(1));

    always_comb begin
        w_lo = (i_pos < w_half) ? w_half : i_pos;
        // upper bound keeps the whole sprite on screen
        w_hi = (w_lo + w_half >= w_size) ? (w_size - w_one - w_half) : w_lo;
        if (i_cfg.gfx) begin
            w_res = w_hi[CALC_W-1] ? '0 : w_hi;
        end else begin
            if (i_pos[CALC_W-1]) begin
                w_res = '0;
            end else if (i_pos > w_tmax) begin
                w_res = w_tmax;
            end else begin
                w_res = i_pos;
            end
        end
    end

    assign o_pos = w_res[POS_W-1:0];

endmodule
